>>> rtl/bpca_pkg.sv
// Types, codes and a helper function shared by the page allocator files.
// No dependencies.
package bpca_pkg;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CHAIN = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFREE = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  // Configuration register
  localparam logic       REG_PAGE_COUNT   = 1'b0;
  localparam logic [8:0] PAGE_COUNT_RESET = 9'd128;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SET_WR,
    ST_CHAIN_CK,
    ST_CHAIN_WR,
    ST_FETCH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] page;
    logic [7:0] link_from;
    logic       used_flag;
    logic       single_page;
    logic       mark_used;
  } in_t;

  typedef struct packed {
    logic [7:0] page_out;
    logic       is_used;
    logic [7:0] next_page;
    logic [1:0] status;
    logic [8:0] pages_touched;
  } out_t;

  // Requests to the bitmap (8 pages a word) and link memories
  typedef struct packed {
    logic       bm_we;
    logic [4:0] bm_wa;
    logic [7:0] bm_wd;
    logic [4:0] bm_ra;
    logic       lk_we;
    logic [7:0] lk_wa;
    logic [7:0] lk_wd;
    logic [7:0] lk_ra;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] word;
    logic [7:0] link;
  } mem_rsp_t;

  // Lowest free page of one bitmap word: {hit, bit index}.
  // Page zero and pages at or above cnt never count as free.
  function automatic logic [3:0] lowest_free(input logic [7:0] word,
                                             input logic [4:0] wbase,
                                             input logic [8:0] cnt);
    logic [3:0] r;
    logic [8:0] pnum;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      pnum = {1'b0, wbase, 3'(i)};
      if (!word[i] && (pnum != 9'd0) && (pnum < cnt)) begin
        r = {1'b1, 3'(i)};
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/bitmap_page_chain_allocator.sv
// Top level of the bitmap page allocator: command sequencer and APB register.
// Depends on bpca_pkg and bpca_store.
//
// After reset the block runs a clearing pass (busy high) that writes page
// zero as used and every other page free with link 0.
// Commands are taken when start is high and busy is low; the result appears
// on result for one cycle with done high, and cannot be held off. The
// memories have one read and one write port each, with registered reads:
// allocate scans the 8-page bitmap words in turn (up to 32), set writes back
// the page's word (not on page zero), and chain reads the link and bitmap
// word of each page walked, then writes the word back.
module bitmap_page_chain_allocator #(
  parameter int MAX_PAGES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bpca_pkg::in_t      item,
  output logic               done,
  output bpca_pkg::out_t     result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int WORDS = (MAX_PAGES + 7) / 8;

  bpca_pkg::state_t   state, state_next;
  bpca_pkg::in_t      op, op_next;
  bpca_pkg::out_t     result_next;
  bpca_pkg::mem_req_t req;
  bpca_pkg::mem_rsp_t rsp;

  logic [8:0] page_count;
  logic [8:0] cnt;
  logic [8:0] cnt_m1;
  logic [7:0] pg, pg_next;
  logic [1:0] stat, stat_next;
  logic [7:0] cur, cur_next;
  logic [8:0] steps, steps_next;
  logic [4:0] w, w_next;
  logic [7:0] clr, clr_next;
  logic       done_next;
  logic [3:0] hit;
  logic [7:0] wd;
  logic       walk;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bpca_pkg::REG_PAGE_COUNT) ? {23'd0, page_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= bpca_pkg::PAGE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bpca_pkg::REG_PAGE_COUNT) begin
      page_count <= pwdata[8:0];
    end
  end

  // Effective page count and last bitmap word to scan
  assign cnt    = (page_count > 9'(MAX_PAGES)) ? 9'(MAX_PAGES) : page_count;
  assign cnt_m1 = cnt - 9'd1;
  assign busy   = (state != bpca_pkg::ST_IDLE);

  bpca_store #(.MAX_PAGES(MAX_PAGES)) u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  // Next state, memory requests and result
  always_comb begin
    state_next  = state;
    op_next     = op;
    pg_next     = pg;
    stat_next   = stat;
    cur_next    = cur;
    steps_next  = steps;
    w_next      = w;
    clr_next    = clr;
    done_next   = 1'b0;
    result_next = result;
    req         = '0;
    hit         = bpca_pkg::lowest_free(rsp.word, w, cnt);
    wd          = rsp.word;
    walk        = (cur != 8'd0) && ({1'b0, cur} < cnt) && (steps < cnt);

    case (state)
      bpca_pkg::ST_CLEAR: begin
        req.bm_we = ({1'b0, clr} < 9'(WORDS));
        req.bm_wa = clr[4:0];
        req.bm_wd = (clr == 8'd0) ? 8'h01 : 8'h00;
        req.lk_we = 1'b1;
        req.lk_wa = clr;
        req.lk_wd = 8'd0;
        clr_next  = clr + 8'd1;
        if (clr == 8'(MAX_PAGES - 1)) begin
          state_next = bpca_pkg::ST_IDLE;
        end
      end

      bpca_pkg::ST_IDLE: begin
        // word 0 for a scan, else the word of the addressed page
        req.bm_ra = (item.cmd == bpca_pkg::CMD_ALLOC) ? 5'd0 : item.page[7:3];
        if (start) begin
          op_next    = item;
          steps_next = 9'd0;
          w_next     = 5'd0;
          pg_next    = 8'd0;
          stat_next  = bpca_pkg::STAT_OK;
          state_next = bpca_pkg::ST_FETCH;
          if (item.cmd == bpca_pkg::CMD_ALLOC) begin
            if (item.link_from != 8'd0 && {1'b0, item.link_from} >= cnt) begin
              stat_next = bpca_pkg::STAT_RANGE;
            end else if (cnt < 9'd2) begin
              stat_next = bpca_pkg::STAT_NOFREE;
            end else begin
              state_next = bpca_pkg::ST_SCAN;
            end
          end else if ({1'b0, item.page} >= cnt) begin
            stat_next = bpca_pkg::STAT_RANGE;
          end else begin
            pg_next = item.page;
            case (item.cmd)
              bpca_pkg::CMD_SET: begin
                if (item.page != 8'd0) begin
                  state_next = bpca_pkg::ST_SET_WR;
                end
              end
              bpca_pkg::CMD_CHAIN: begin
                cur_next   = item.page;
                state_next = bpca_pkg::ST_CHAIN_CK;
              end
              default: begin
                state_next = bpca_pkg::ST_FETCH;
              end
            endcase
          end
        end
      end

      // One bitmap word per cycle, next word read ahead
      bpca_pkg::ST_SCAN: begin
        req.bm_ra = (w == cnt_m1[7:3]) ? w : w + 5'd1;
        if (hit[3]) begin
          wd[hit[2:0]] = 1'b1;
          req.bm_we    = op.mark_used;
          req.bm_wa    = w;
          req.bm_wd    = wd;
          req.lk_we    = (op.link_from != 8'd0);
          req.lk_wa    = op.link_from;
          req.lk_wd    = {w, hit[2:0]};
          pg_next      = {w, hit[2:0]};
          state_next   = bpca_pkg::ST_FETCH;
        end else if (w == cnt_m1[7:3]) begin
          stat_next  = bpca_pkg::STAT_NOFREE;
          state_next = bpca_pkg::ST_FETCH;
        end else begin
          w_next = w + 5'd1;
        end
      end

      bpca_pkg::ST_SET_WR: begin
        wd[pg[2:0]] = op.used_flag;
        req.bm_we   = 1'b1;
        req.bm_wa   = pg[7:3];
        req.bm_wd   = wd;
        state_next  = bpca_pkg::ST_FETCH;
      end

      // Check the walk condition and read the current page
      bpca_pkg::ST_CHAIN_CK: begin
        req.bm_ra = cur[7:3];
        req.lk_ra = cur;
        state_next = walk ? bpca_pkg::ST_CHAIN_WR : bpca_pkg::ST_FETCH;
      end

      // Mark the current page and follow its link
      bpca_pkg::ST_CHAIN_WR: begin
        wd[cur[2:0]] = op.used_flag;
        req.bm_we    = 1'b1;
        req.bm_wa    = cur[7:3];
        req.bm_wd    = wd;
        cur_next     = op.single_page ? 8'd0 : rsp.link;
        steps_next   = steps + 9'd1;
        state_next   = bpca_pkg::ST_CHAIN_CK;
      end

      bpca_pkg::ST_FETCH: begin
        req.bm_ra  = pg[7:3];
        req.lk_ra  = pg;
        state_next = bpca_pkg::ST_RESP;
      end

      bpca_pkg::ST_RESP: begin
        result_next.page_out      = pg;
        result_next.is_used       = rsp.word[pg[2:0]];
        result_next.next_page     = rsp.link;
        result_next.status        = stat;
        result_next.pages_touched = steps;
        done_next                 = 1'b1;
        state_next                = bpca_pkg::ST_IDLE;
      end

      default: begin
        state_next = bpca_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpca_pkg::ST_CLEAR;
      clr   <= 8'd0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      done  <= done_next;
    end
  end

  // Command context and result payload
  always_ff @(posedge clk) begin
    op     <= op_next;
    pg     <= pg_next;
    stat   <= stat_next;
    cur    <= cur_next;
    steps  <= steps_next;
    w      <= w_next;
    result <= result_next;
  end

  // A result strobe comes only from the response state
  a_done_from_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == bpca_pkg::ST_RESP))
    else $error("done without response state");

  // The chain walk never counts past the effective page count
  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bpca_pkg::ST_CHAIN_CK) |-> (steps <= cnt))
    else $error("chain step count beyond page count");

  // Page zero stays used in every bitmap write
  a_page0_used: assert property (@(posedge clk) disable iff (rst)
    (req.bm_we && req.bm_wa == 5'd0) |-> req.bm_wd[0])
    else $error("page zero written as free");

  // Error results point at page zero, read as used
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != bpca_pkg::STAT_OK) |->
      (result.page_out == 8'd0 && result.is_used && result.pages_touched == 9'd0))
    else $error("error result with page data");

endmodule

>>> rtl/bpca_store.sv
// Used-bit memory (8 pages per word) and next-page link memory.
// Depends on bpca_pkg for the request and response structs.
module bpca_store #(
  parameter int MAX_PAGES = 256
) (
  input  logic               clk,
  input  bpca_pkg::mem_req_t req,
  output bpca_pkg::mem_rsp_t rsp
);

  localparam int WORDS = (MAX_PAGES + 7) / 8;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = $clog2(MAX_PAGES);

  logic [7:0] bitmap [WORDS];
  logic [7:0] links  [MAX_PAGES];

  // Bitmap and links: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (req.bm_we) begin
      bitmap[req.bm_wa[WW-1:0]] <= req.bm_wd;
    end
    if (req.lk_we) begin
      links[req.lk_wa[PW-1:0]] <= req.lk_wd;
    end
    rsp.word <= bitmap[req.bm_ra[WW-1:0]];
    rsp.link <= links[req.lk_ra[PW-1:0]];
  end

endmodule

>>> sim/bitmap_page_chain_allocator_tb.sv
// Self-checking testbench for bitmap_page_chain_allocator: command driver, result monitor,
// a page-table predictor and the page_count register port. Depends on bpca_pkg and the
// block's RTL.
`timescale 1ns / 100ps

module bitmap_page_chain_allocator_tb;

  localparam int PAGES = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Two copies of the page table: one used to plan stimulus, one to check results
  localparam int GEN_VIEW = 0;
  localparam int CHECK_VIEW = 1;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  bpca_pkg::in_t  item;
  logic           done;
  bpca_pkg::out_t result;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [2:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  bitmap_page_chain_allocator #(.MAX_PAGES(PAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Predicted page table state
  bit         page_used[2][PAGES];
  logic [7:0] next_link[2][PAGES];
  logic [8:0] count_reg[2];

  bpca_pkg::in_t  pending_items[$];
  bpca_pkg::out_t expected_results[$];

  int  errors = 0;
  int  cycles = 0;
  int  gap_left;
  bit  quiet = 0;
  int  cmd_seen[4] = '{0, 0, 0, 0};
  int  results_checked = 0;
  int  longest_walk = 0;
  int  settings = 0;

  function automatic void reset_table(input int m);
    for (int p = 0; p < PAGES; p++) begin
      page_used[m][p] = (p == 0);
      next_link[m][p] = 8'd0;
    end
    count_reg[m] = bpca_pkg::PAGE_COUNT_RESET;
  endfunction

  function automatic int eff_count(input int m);
    return (count_reg[m] > PAGES) ? PAGES : int'(count_reg[m]);
  endfunction

  function automatic bpca_pkg::out_t page_view(input int m, input int p,
                                               input logic [1:0] st, input int touched);
    bpca_pkg::out_t r;
    r.page_out      = 8'(p);
    r.is_used       = page_used[m][p];
    r.next_page     = next_link[m][p];
    r.status        = st;
    r.pages_touched = 9'(touched);
    return r;
  endfunction

  // Runs one command against a copy of the page table and returns its result
  function automatic bpca_pkg::out_t run_command(input int m, input bpca_pkg::in_t it);
    bpca_pkg::out_t r;
    int   cnt;
    int   found;
    int   cur;
    int   steps;
    cnt = eff_count(m);
    r = '0;
    r.is_used = 1'b1;
    if (it.cmd == bpca_pkg::CMD_ALLOC) begin
      found = 0;
      if (it.link_from != 0 && it.link_from >= cnt) begin
        r.status = bpca_pkg::STAT_RANGE;
      end else begin
        for (int p = 1; p < cnt && found == 0; p++) begin
          if (!page_used[m][p]) found = p;
        end
        if (found == 0) begin
          r.status = bpca_pkg::STAT_NOFREE;
        end else begin
          if (it.mark_used) page_used[m][found] = 1'b1;
          if (it.link_from != 0) next_link[m][it.link_from] = 8'(found);
          r = page_view(m, found, bpca_pkg::STAT_OK, 0);
        end
      end
    end else if (it.page >= cnt) begin
      r.status = bpca_pkg::STAT_RANGE;
    end else begin
      steps = 0;
      if (it.cmd == bpca_pkg::CMD_SET && it.page != 0) page_used[m][it.page] = it.used_flag;
      if (it.cmd == bpca_pkg::CMD_CHAIN) begin
        // walk stops at link 0, a link past the count, or after count pages
        cur = it.page;
        while (cur != 0 && cur < cnt && steps < cnt) begin
          page_used[m][cur] = it.used_flag;
          cur = it.single_page ? 0 : int'(next_link[m][cur]);
          steps++;
        end
      end
      r = page_view(m, it.page, bpca_pkg::STAT_OK, steps);
    end
    return r;
  endfunction

  // Queue a command and advance the planning copy so later items can use its result
  function automatic bpca_pkg::out_t queue_item(input bpca_pkg::in_t it);
    pending_items.push_back(it);
    return run_command(GEN_VIEW, it);
  endfunction

  function automatic bpca_pkg::in_t mk(input logic [1:0] cmd, input int page, input int from,
                                       input bit used, input bit single, input bit mark);
    bpca_pkg::in_t it;
    it.cmd         = cmd;
    it.page        = 8'(page);
    it.link_from   = 8'(from);
    it.used_flag   = used;
    it.single_page = single;
    it.mark_used   = mark;
    return it;
  endfunction

  // Loose single command: mostly in-range pages, some anywhere
  function automatic bpca_pkg::in_t random_item(input int cnt);
    bpca_pkg::in_t it;
    int  pick;
    it = bpca_pkg::in_t'($urandom);
    if (cnt > 0 && $urandom_range(0, 99) < 85) it.page = 8'($urandom_range(0, cnt - 1));
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      it.link_from = 8'd0;
    end else if (pick < 17 && cnt > 1) begin
      it.link_from = 8'($urandom_range(1, cnt - 1));
    end
    return it;
  endfunction

  // Mostly linked allocation runs followed by a walk of the new chain, plus loose commands
  task automatic queue_random(input int n);
    int   made;
    int   k;
    int   cnt;
    int   prev;
    int   head;
    bpca_pkg::in_t  it;
    bpca_pkg::out_t r;
    made = 0;
    while (made < n) begin
      cnt = eff_count(GEN_VIEW);
      if ($urandom_range(0, 99) < 45) begin
        k = $urandom_range(1, 6);
        prev = (cnt > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, cnt - 1) : 0;
        head = 0;
        repeat (k) begin
          it = bpca_pkg::in_t'($urandom);
          it.cmd = bpca_pkg::CMD_ALLOC;
          it.link_from = 8'(prev);
          it.mark_used = ($urandom_range(0, 9) != 0);
          r = queue_item(it);
          if (r.status == bpca_pkg::STAT_OK) begin
            if (head == 0) head = r.page_out;
            prev = r.page_out;
          end
        end
        it = random_item(cnt);
        it.cmd = bpca_pkg::CMD_CHAIN;
        if (head != 0) it.page = 8'(head);
        it.used_flag = ($urandom_range(0, 9) < 4);
        it.single_page = ($urandom_range(0, 4) == 0);
        void'(queue_item(it));
        made += k + 1;
      end else begin
        void'(queue_item(random_item(cnt)));
        made++;
      end
    end
  endtask

  // Wait until the sender is empty and every result is in
  task automatic wait_idle;
    @(negedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_cycle(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'(bpca_pkg::REG_PAGE_COUNT) << 2;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_page_count(input logic [8:0] value);
    logic [31:0] rd;
    reg_cycle(1'b0, 32'd0, rd);
    if (rd !== {23'd0, value}) begin
      errors++;
      $display("%0t: page_count readback expected %0d got %0d", $time, value, rd);
    end
  endtask

  task automatic set_page_count(input logic [8:0] value);
    logic [31:0] rd;
    wait_idle();
    reg_cycle(1'b1, {23'd0, value}, rd);
    check_page_count(value);
    count_reg[GEN_VIEW]   = value;
    count_reg[CHECK_VIEW] = value;
    settings++;
  endtask

  // Clock and timeout
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items waiting and %0d results due", $time,
               pending_items.size(), expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Driver: presents queued items with random gaps, predicts each accepted item
  always @(posedge clk) begin
    logic next_start;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_results.push_back(run_command(CHECK_VIEW, item));
        cmd_seen[item.cmd]++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          next_start = 1'b1;
          if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 6);
        end
      end
      start <= next_start;
    end
  end

  // Monitor: compares each result with the oldest prediction
  always @(posedge clk) begin
    bpca_pkg::out_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, result);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.pages_touched > longest_walk) longest_walk = want.pages_touched;
        if (result !== want) begin
          errors++;
          if (result.page_out !== want.page_out)
            $display("%0t: page_out expected %0d got %0d", $time, want.page_out,
                     result.page_out);
          if (result.is_used !== want.is_used)
            $display("%0t: is_used expected %0d got %0d", $time, want.is_used,
                     result.is_used);
          if (result.next_page !== want.next_page)
            $display("%0t: next_page expected %0d got %0d", $time, want.next_page,
                     result.next_page);
          if (result.status !== want.status)
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     result.status);
          if (result.pages_touched !== want.pages_touched)
            $display("%0t: pages_touched expected %0d got %0d", $time,
                     want.pages_touched, result.pages_touched);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    clk     = 1'b0;
    rst     = 1'b1;
    start   = 1'b0;
    item    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    reset_table(GEN_VIEW);
    reset_table(CHECK_VIEW);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // let the clearing pass finish, then check the reset count
    @(negedge clk);
    while (busy) @(negedge clk);
    check_page_count(bpca_pkg::PAGE_COUNT_RESET);

    // Directed: page zero, range edges, linked allocation, single and cyclic walks
    void'(queue_item(mk(bpca_pkg::CMD_QUERY, 0, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_QUERY, 127, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_QUERY, 128, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_QUERY, 255, 255, 1, 1, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_SET, 0, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 0, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 0, 0, 0, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 1, 0, 0, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 2, 0, 0, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 128, 0, 0, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 255, 255, 1, 1, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 1, 0, 0, 1, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 1, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 1, 0, 0, 0, 0)));
    // closes the chain into a loop: the walk stops after count pages
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 3, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 2, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_SET, 127, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_SET, 128, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 200, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_QUERY, 3, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 3, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_SET, 5, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_SET, 127, 0, 0, 0, 0)));

    set_page_count(9'd256);
    queue_random(220);

    // two pages: page 1 only, so the table fills at once
    set_page_count(9'd2);
    void'(queue_item(mk(bpca_pkg::CMD_SET, 1, 0, 1, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 0, 0, 0, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_SET, 1, 0, 0, 0, 0)));
    void'(queue_item(mk(bpca_pkg::CMD_ALLOC, 0, 1, 0, 0, 1)));
    void'(queue_item(mk(bpca_pkg::CMD_CHAIN, 1, 0, 1, 0, 0)));
    queue_random(30);

    // above the page limit: saturates to the full table
    set_page_count(9'd511);
    queue_random(150);

    set_page_count(9'd1);
    queue_random(20);
    set_page_count(9'd0);
    queue_random(20);
    set_page_count(9'd9);
    queue_random(100);
    set_page_count(9'd40);
    queue_random(230);
    set_page_count(9'd200);
    queue_random(150);

    // back-to-back commands to the end
    set_page_count(9'd256);
    quiet = 1;
    queue_random(150);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Checked %0d results: %0d allocate, %0d set, %0d chain, %0d query commands",
             results_checked, cmd_seen[bpca_pkg::CMD_ALLOC], cmd_seen[bpca_pkg::CMD_SET],
             cmd_seen[bpca_pkg::CMD_CHAIN], cmd_seen[bpca_pkg::CMD_QUERY]);
    $display("%0d page_count settings written, longest chain walk %0d pages",
             settings, longest_walk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
